// File: rtl/core/bma_pkg.sv
package bma_pkg;

   localparam int BLOCK_DIM_DEF = 16;

   localparam int OPCODE_W  = 3;
   localparam int INDEX_W   = 4;
   localparam int VALUE_W   = 16;
   localparam int C_W       = 48;
   localparam int DIM_W     = 5;
   localparam int DIM_CMP_W = 7;
   localparam int PROD_W    = 2 * VALUE_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OPCODE_W-1:0] OP_WRITE_A = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_WRITE_B = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_ACCUM   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_READ_C  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR_C = 3'd4;

   localparam logic REG_ACTIVE_DIM = 1'b0;
   localparam logic [DIM_W-1:0] ACTIVE_DIM_RESET = 5'd16;

   localparam logic signed [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};
   localparam logic signed [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};

   typedef struct packed {
      logic                  sat;
      logic signed [C_W-1:0] value;
   } c_entry_type;

   typedef struct packed {
      logic issue;
      logic first;
   } mac_ctrl_type;

endpackage

// File: rtl/core/bma_ab_mem.sv
module bma_ab_mem #(
   parameter int AW = 8
) (
   input  logic                              clock,
   input  logic                              wr_en_a,
   input  logic                              wr_en_b,
   input  logic [AW-1:0]                     wr_addr,
   input  logic [bma_pkg::VALUE_W-1:0]       wr_data,
   input  logic                              rd_en,
   input  logic [AW-1:0]                     rd_addr_a,
   input  logic [AW-1:0]                     rd_addr_b,
   output logic [bma_pkg::VALUE_W-1:0]       rd_data_a,
   output logic [bma_pkg::VALUE_W-1:0]       rd_data_b
);
   import bma_pkg::*;

   localparam int DEPTH = 2 ** AW;

   logic [1:0][VALUE_W-1:0] ab_ram [DEPTH];
   logic [VALUE_W-1:0]      rd_data_a_ff;
   logic [VALUE_W-1:0]      rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en_a) begin
         ab_ram[wr_addr][0] <= wr_data;
      end
      if (wr_en_b) begin
         ab_ram[wr_addr][1] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= ab_ram[rd_addr_a][0];
         rd_data_b_ff <= ab_ram[rd_addr_b][1];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: rtl/core/bma_c_mem.sv
module bma_c_mem #(
   parameter int AW = 8
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  bma_pkg::c_entry_type  wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output bma_pkg::c_entry_type  rd_data
);
   import bma_pkg::*;

   localparam int DEPTH = 2 ** AW;

   c_entry_type c_ram [DEPTH];
   c_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         c_ram[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= c_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bma_mac.sv
module bma_mac #(
   parameter int SUM_W = 36
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bma_pkg::mac_ctrl_type              ctrl,
   input  logic [bma_pkg::VALUE_W-1:0]        a_data,
   input  logic [bma_pkg::VALUE_W-1:0]        b_data,
   output logic                               busy,
   output logic signed [SUM_W-1:0]            sum
);
   import bma_pkg::*;

   logic                     v1_ff, v1_in;
   logic                     first1_ff, first1_in;
   logic                     v2_ff, v2_in;
   logic                     first2_ff, first2_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [SUM_W-1:0]  prod_ext;

   assign v1_in     = ctrl.issue;
   assign first1_in = ctrl.first;
   assign v2_in     = v1_ff;
   assign first2_in = first1_ff;
   assign prod_in   = $signed(a_data) * $signed(b_data);
   assign prod_ext  = {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      sum_in = sum_ff;
      if (v2_ff) begin
         sum_in = first2_ff ? prod_ext : sum_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff <= first1_in;
      first2_ff <= first2_in;
      prod_ff   <= prod_in;
      sum_ff    <= sum_in;
   end

   assign busy = v1_ff | v2_ff;
   assign sum  = sum_ff;

endmodule

// File: rtl/core/block_matmul_accumulate.sv
// Channel | Direction | Handshake            | Beat contents
// req     | in        | req_valid, req_stall | opcode, row, col, value
// rsp     | out       | rsp_valid, rsp_stall | c_value, saturated
// csr     | in/out    | APB, pready high     | active_dim at byte address 0
//
// Writes of A or B and unused opcodes leave the sequencer idle; a read of C passes through S_READ.
// An accumulate walks every element of C for an active size d through the single read port
// pair of the A/B memory and the multiply-add pipe, and drains the pipe before each write-back.
// Reset and clear C sweep the C memory, one entry a cycle, all 2**(2*clog2(BLOCK_DIM)) entries.
// A read of C is held off while a finished beat waits and rsp_stall is high.
module block_matmul_accumulate #(
   parameter int BLOCK_DIM = bma_pkg::BLOCK_DIM_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bma_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic [bma_pkg::INDEX_W-1:0]          req_row,
   input  logic [bma_pkg::INDEX_W-1:0]          req_col,
   input  logic signed [bma_pkg::VALUE_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bma_pkg::C_W-1:0]       rsp_c_value,
   output logic                                 rsp_saturated,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bma_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [bma_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [bma_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import bma_pkg::*;

   localparam int IDX_W = $clog2(BLOCK_DIM);
   localparam int AW    = 2 * IDX_W;
   localparam int SUM_W = PROD_W + IDX_W;
   localparam int TOT_W = C_W + 1;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_READ  = 5'b00100,
      S_MAC   = 5'b01000,
      S_DRAIN = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [DIM_W-1:0]      active_dim_ff, active_dim_in;
   logic [IDX_W-1:0]      i_ff, i_in;
   logic [IDX_W-1:0]      j_ff, j_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   logic [AW-1:0]         clr_ctr_ff, clr_ctr_in;
   logic                  inside_ff, inside_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [C_W-1:0] rsp_c_value_ff, rsp_c_value_in;
   logic                  rsp_saturated_ff, rsp_saturated_in;

   logic [DIM_CMP_W-1:0]  dim_raw;
   logic [DIM_CMP_W-1:0]  dim_eff;
   logic [IDX_W-1:0]      last_idx;
   logic                  in_block;
   logic [IDX_W-1:0]      row_idx;
   logic [IDX_W-1:0]      col_idx;
   logic                  req_accept;
   logic                  csr_wr;
   logic                  csr_sel_dim;

   logic                  ab_wr_a;
   logic                  ab_wr_b;
   logic [VALUE_W-1:0]    ab_rd_a;
   logic [VALUE_W-1:0]    ab_rd_b;
   mac_ctrl_type          mac_ctrl;
   logic                  mac_busy;
   logic signed [SUM_W-1:0] mac_sum;

   logic                  c_wr_en;
   logic [AW-1:0]         c_wr_addr;
   c_entry_type           c_wr_data;
   logic                  c_rd_en;
   logic [AW-1:0]         c_rd_addr;
   c_entry_type           c_rd_data;
   logic signed [TOT_W-1:0] c_total;
   c_entry_type           c_wb;
   logic                  wb_now;

   // Configuration port.
   assign csr_pready  = 1'b1;
   assign csr_wr      = csr_psel & csr_penable & csr_pwrite;
   assign csr_sel_dim = (csr_paddr[CSR_ADDR_W-1:2] == REG_ACTIVE_DIM);
   assign active_dim_in = (csr_wr && csr_sel_dim) ? csr_pwdata[DIM_W-1:0] : active_dim_ff;
   assign csr_prdata  = csr_sel_dim ? {{(CSR_DATA_W-DIM_W){1'b0}}, active_dim_ff} : '0;

   // Active size, clamped to one and to the block size.
   always_comb begin
      dim_raw = {{(DIM_CMP_W-DIM_W){1'b0}}, active_dim_ff};
      if (dim_raw == '0) begin
         dim_eff = DIM_CMP_W'(1);
      end else if (dim_raw > DIM_CMP_W'(BLOCK_DIM)) begin
         dim_eff = DIM_CMP_W'(BLOCK_DIM);
      end else begin
         dim_eff = dim_raw;
      end
   end

   assign last_idx = IDX_W'(dim_eff - DIM_CMP_W'(1));
   assign in_block = (DIM_CMP_W'(req_row) < dim_eff) && (DIM_CMP_W'(req_col) < dim_eff);
   assign row_idx  = IDX_W'(req_row);
   assign col_idx  = IDX_W'(req_col);

   assign req_stall  = (state_ff != S_IDLE) ||
                       ((req_opcode == OP_READ_C) && rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign ab_wr_a = req_accept && (req_opcode == OP_WRITE_A) && in_block;
   assign ab_wr_b = req_accept && (req_opcode == OP_WRITE_B) && in_block;

   assign mac_ctrl.issue = (state_ff == S_MAC);
   assign mac_ctrl.first = (k_ff == '0);

   // Write-back of one C element: exact sum, then one clamp to 48 bits.
   assign c_total = {c_rd_data.value[C_W-1], c_rd_data.value} +
                    {{(TOT_W-SUM_W){mac_sum[SUM_W-1]}}, mac_sum};

   always_comb begin
      c_wb.sat   = c_rd_data.sat;
      c_wb.value = c_total[C_W-1:0];
      if (c_total[TOT_W-1] != c_total[C_W-1]) begin
         c_wb.sat   = 1'b1;
         c_wb.value = c_total[TOT_W-1] ? C_MIN : C_MAX;
      end
   end

   assign wb_now = (state_ff == S_DRAIN) && !mac_busy;

   always_comb begin
      c_wr_en   = 1'b0;
      c_wr_addr = {i_ff, j_ff};
      c_wr_data = c_wb;
      if (state_ff == S_CLEAR) begin
         c_wr_en   = 1'b1;
         c_wr_addr = clr_ctr_ff;
         c_wr_data = '0;
      end else if (wb_now) begin
         c_wr_en = 1'b1;
      end
   end

   always_comb begin
      c_rd_en   = 1'b0;
      c_rd_addr = {i_ff, j_ff};
      if (req_accept && (req_opcode == OP_READ_C)) begin
         c_rd_en   = in_block;
         c_rd_addr = {row_idx, col_idx};
      end else if ((state_ff == S_MAC) && (k_ff == last_idx)) begin
         c_rd_en = 1'b1;
      end
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      clr_ctr_in = clr_ctr_ff;
      inside_in  = inside_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_ctr_in = clr_ctr_ff + AW'(1);
            if (clr_ctr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_opcode)
                  OP_ACCUM: begin
                     state_in = S_MAC;
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                  end
                  OP_READ_C: begin
                     state_in  = S_READ;
                     inside_in = in_block;
                  end
                  OP_CLEAR_C: begin
                     state_in   = S_CLEAR;
                     clr_ctr_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         S_MAC: begin
            if (k_ff == last_idx) begin
               k_in     = '0;
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            if (!mac_busy) begin
               state_in = S_MAC;
               if (j_ff == last_idx) begin
                  j_in = '0;
                  if (i_ff == last_idx) begin
                     state_in = S_IDLE;
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                  end
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_c_value_in   = rsp_c_value_ff;
      rsp_saturated_in = rsp_saturated_ff;
      if (state_ff == S_READ) begin
         rsp_valid_in     = 1'b1;
         rsp_c_value_in   = inside_ff ? c_rd_data.value : '0;
         rsp_saturated_in = inside_ff & c_rd_data.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ctr_ff    <= '0;
         active_dim_ff <= ACTIVE_DIM_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ctr_ff    <= clr_ctr_in;
         active_dim_ff <= active_dim_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff             <= i_in;
      j_ff             <= j_in;
      k_ff             <= k_in;
      inside_ff        <= inside_in;
      rsp_c_value_ff   <= rsp_c_value_in;
      rsp_saturated_ff <= rsp_saturated_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_c_value   = rsp_c_value_ff;
   assign rsp_saturated = rsp_saturated_ff;

   bma_ab_mem #(
      .AW(AW)
   ) u_ab_mem (
      .clock     (clock),
      .wr_en_a   (ab_wr_a),
      .wr_en_b   (ab_wr_b),
      .wr_addr   ({row_idx, col_idx}),
      .wr_data   (req_value),
      .rd_en     (mac_ctrl.issue),
      .rd_addr_a ({i_ff, k_ff}),
      .rd_addr_b ({k_ff, j_ff}),
      .rd_data_a (ab_rd_a),
      .rd_data_b (ab_rd_b)
   );

   bma_mac #(
      .SUM_W(SUM_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .a_data (ab_rd_a),
      .b_data (ab_rd_b),
      .busy   (mac_busy),
      .sum    (mac_sum)
   );

   bma_c_mem #(
      .AW(AW)
   ) u_c_mem (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_en   (c_rd_en),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   // The output register must be free when a read of C completes.
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("read of C completes while a beat still waits");

   // A new beat on rsp only ever follows a read of C.
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_READ))
      else $error("rsp beat without a read of C");

   // Each element's dot product starts with an empty multiply-add pipe.
   a_pipe_empty_at_start: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MAC) && (k_ff == '0)) |-> !mac_busy)
      else $error("dot products overlap in the multiply-add pipe");

   // An accumulate holds off the next beat on req.
   a_accum_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_opcode == OP_ACCUM)) |=> req_stall)
      else $error("accumulate did not stall req");

endmodule
